// ----- hw/rtl/swss_pkg.sv -----
// Types, codes and constants for the stop-and-wait segment sender.
package swss_pkg;

  localparam int unsigned SegmentBytes = 80;
  localparam int unsigned SeqBits      = 8;

  localparam int unsigned SeqMax   = (1 << SeqBits) - 1;
  localparam int unsigned SegLimit = (SeqMax > 255) ? 255 : SeqMax;

  // Exact reciprocal for quotients of 17-bit dividends.
  localparam int unsigned RecipShift = 25;
  localparam logic [25:0] RecipMult  = 26'(((1 << RecipShift) + SegmentBytes - 1)
                                           / SegmentBytes);

  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindReply = 2'd1;
  localparam logic [1:0] KindMiss  = 2'd2;

  localparam logic ResSegment = 1'b0;
  localparam logic ResStatus  = 1'b1;

  localparam logic [2:0] FlagNone  = 3'b000;
  localparam logic [2:0] FlagProbe = 3'b001;
  localparam logic [2:0] FlagLast  = 3'b100;

  localparam logic [2:0] StatDelivered = 3'd0;
  localparam logic [2:0] StatNoConn    = 3'd1;
  localparam logic [2:0] StatLost      = 3'd2;
  localparam logic [2:0] StatRejected  = 3'd3;
  localparam logic [2:0] StatTooLong   = 3'd4;

  localparam logic [1:0] CfgProbeTries = 2'd0;
  localparam logic [1:0] CfgDataTries  = 2'd1;

  localparam logic [3:0] ProbeTriesReset = 4'd3;
  localparam logic [3:0] DataTriesReset  = 4'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] message_length;
    logic [7:0]  reply_seq;
    logic [2:0]  reply_flags;
  } cmd_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  seq_number;
    logic [2:0]  segment_flags;
    logic [15:0] payload_offset;
    logic [7:0]  payload_length;
    logic [7:0]  probe_count;
    logic [2:0]  status;
  } res_t;

endpackage

// ----- hw/rtl/stop_and_wait_segment_sender.sv -----
// Sender side of a stop-and-wait transport: segment headers and final status.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle while no result stalls; a request that causes
// no result is still taken. A held result blocks requests only while it is stalled.
// Reset: synchronous; idle, all transfer state zero, probe_tries 3, data_tries 5.
module stop_and_wait_segment_sender
  import swss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  logic [3:0]  probe_tries;
  logic [3:0]  data_tries;

  logic        busy, busy_next;
  logic [7:0]  seg, seg_next;
  logic [7:0]  count, count_next;
  logic [3:0]  miss, miss_next;
  logic [15:0] total, total_next;
  logic [15:0] offset, offset_next;

  logic        fire;
  logic        load;
  res_t        res_next;

  logic [16:0] div_num;
  logic [42:0] div_prod;
  logic [16:0] div_cnt;
  logic        too_long;
  logic [3:0]  miss_inc;
  logic [15:0] offset_adv;

  function automatic res_t seg_result(input logic [7:0] s, input logic [7:0] c,
                                      input logic [15:0] off, input logic [15:0] tot);
    res_t        r;
    logic [15:0] rem;
    r   = '0;
    rem = tot - off;
    r.result_kind = ResSegment;
    r.status      = StatDelivered;
    if (s == 8'd0) begin
      r.segment_flags = FlagProbe;
      r.probe_count   = c;
    end else begin
      r.seq_number     = s;
      r.segment_flags  = (s == c) ? FlagLast : FlagNone;
      r.payload_offset = off;
      if (off < tot) begin
        r.payload_length = (rem > 16'(SegmentBytes)) ? 8'(SegmentBytes) : rem[7:0];
      end
    end
    return r;
  endfunction

  function automatic res_t stat_result(input logic [2:0] code);
    res_t r;
    r = '0;
    r.result_kind = ResStatus;
    r.status      = code;
    return r;
  endfunction

  assign cmd_stall = res_valid && res_stall;
  assign fire      = cmd_valid && !cmd_stall;
  assign cfg_ready = 1'b1;

  assign div_num    = {1'b0, cmd.message_length} + 17'(SegmentBytes - 1);
  assign div_prod   = div_num * RecipMult;
  assign div_cnt    = div_prod[RecipShift +: 17];
  assign too_long   = div_cnt > 17'(SegLimit);
  assign miss_inc   = miss + 4'd1;
  assign offset_adv = (seg == 8'd0) ? 16'd0 : 16'({1'b0, offset} + 17'(SegmentBytes));

  always_comb begin
    busy_next   = busy;
    seg_next    = seg;
    count_next  = count;
    miss_next   = miss;
    total_next  = total;
    offset_next = offset;
    load        = 1'b0;
    res_next    = '0;
    unique case (cmd.kind)
      KindStart: begin
        load = 1'b1;
        if (too_long) begin
          busy_next = 1'b0;
          res_next  = stat_result(StatTooLong);
        end else begin
          busy_next   = 1'b1;
          seg_next    = 8'd0;
          count_next  = div_cnt[7:0];
          miss_next   = 4'd0;
          total_next  = cmd.message_length;
          offset_next = 16'd0;
          res_next    = seg_result(8'd0, div_cnt[7:0], 16'd0, cmd.message_length);
        end
      end
      KindReply: begin
        if (busy) begin
          load      = 1'b1;
          miss_next = 4'd0;
          if (seg == 8'd0 && cmd.reply_seq == 8'd0 && cmd.reply_flags == FlagNone) begin
            busy_next = 1'b0;
            res_next  = stat_result(StatRejected);
          end else if (cmd.reply_seq != seg) begin
            res_next = seg_result(seg, count, offset, total);
          end else if (seg >= count) begin
            busy_next = 1'b0;
            res_next  = stat_result(StatDelivered);
          end else begin
            seg_next    = seg + 8'd1;
            offset_next = offset_adv;
            res_next    = seg_result(seg + 8'd1, count, offset_adv, total);
          end
        end
      end
      KindMiss: begin
        if (busy) begin
          load      = 1'b1;
          miss_next = miss_inc;
          if (seg == 8'd0 && miss_inc >= probe_tries) begin
            busy_next = 1'b0;
            res_next  = stat_result(StatNoConn);
          end else if (miss_inc >= data_tries) begin
            busy_next = 1'b0;
            res_next  = stat_result(StatLost);
          end else begin
            res_next = seg_result(seg, count, offset, total);
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_tries <= ProbeTriesReset;
      data_tries  <= DataTriesReset;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CfgProbeTries) begin
        probe_tries <= cfg_data;
      end else if (cfg_index == CfgDataTries) begin
        data_tries <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      seg    <= 8'd0;
      count  <= 8'd0;
      miss   <= 4'd0;
      total  <= 16'd0;
      offset <= 16'd0;
    end else if (fire) begin
      busy   <= busy_next;
      seg    <= seg_next;
      count  <= count_next;
      miss   <= miss_next;
      total  <= total_next;
      offset <= offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= load;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && load) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_start_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.kind == KindStart |=> res_valid)
    else $error("start request produced no result");

  a_seg_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> seg <= count)
    else $error("current segment beyond segment count");

  a_status_ends_transfer: assert property (@(posedge clk) disable iff (rst)
    fire && load && res_next.result_kind == ResStatus |=> !busy)
    else $error("status result left transfer running");

  a_accept_when_room: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !cmd_stall)
    else $error("request stalled with empty result register");
`endif

endmodule
